@@ sv/passkey_pairing_session_fsm_assert.svh @@
// Assertion macros shared by the passkey pairing session modules.
`ifndef PASSKEY_PAIRING_SESSION_FSM_ASSERT_SVH
`define PASSKEY_PAIRING_SESSION_FSM_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define PPS_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("pps assertion failed");

// The condition implies the consequence in the following cycle.
`define PPS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("pps assertion failed");

`endif

@@ sv/pps_pkg.sv @@
// Package with codes, types and constants of the passkey pairing session block.
package pps_pkg;

   localparam logic [15:0] NO_CONNECTION_HANDLE = 16'hFFFF;

   localparam logic [3:0] OP_CONNECT     = 4'd0;
   localparam logic [3:0] OP_PASSKEY     = 4'd1;
   localparam logic [3:0] OP_UNSUPPORTED = 4'd2;
   localparam logic [3:0] OP_RESPONSE    = 4'd3;
   localparam logic [3:0] OP_TIMEOUT     = 4'd4;
   localparam logic [3:0] OP_COMPLETE    = 4'd5;
   localparam logic [3:0] OP_FAIL_CLOSED = 4'd6;
   localparam logic [3:0] OP_DISCONNECT  = 4'd7;
   localparam logic [3:0] OP_DISABLE     = 4'd8;
   localparam logic [3:0] OP_RESET       = 4'd9;
   localparam logic [3:0] OP_VALIDATE    = 4'd10;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_STALE       = 3'd1;
   localparam logic [2:0] ST_DUP         = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED   = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ST_NOT_PENDING = 3'd5;
   localparam logic [2:0] ST_STALE_ID    = 3'd6;
   localparam logic [2:0] ST_STALE_CONN  = 3'd7;

   localparam logic [1:0] LIVE_IDLE     = 2'd0;
   localparam logic [1:0] LIVE_SECURING = 2'd1;
   localparam logic [1:0] LIVE_WAITING  = 2'd2;

   localparam logic [3:0] LAST_NONE      = 4'd0;
   localparam logic [3:0] LAST_POLICY    = 4'd1;
   localparam logic [3:0] LAST_TIMEOUT   = 4'd2;
   localparam logic [3:0] LAST_PEER_DISC = 4'd3;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] gen;
      logic [15:0] handle;
      logic [31:0] pair_id;
      logic [3:0]  result;
   } event_type;

   typedef struct packed {
      logic [1:0]  live;
      logic [3:0]  last;
      logic [31:0] gen;
      logic [15:0] handle;
      logic [31:0] pair_id;
      logic        active;
      logic        consumed;
      logic        exhausted;
   } session_type;

   typedef struct packed {
      logic [2:0]  status;
      session_type sess;
   } result_type;

endpackage

@@ sv/pps_core.sv @@
// Session state registers and the next-state logic for one event.
`include "passkey_pairing_session_fsm_assert.svh"

module pps_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pps_pkg::event_type  ev,
   output pps_pkg::result_type res
);
   import pps_pkg::*;

   session_type sess_ff;
   session_type sess_in;
   logic [31:0] next_id_ff;
   logic [31:0] next_id_in;
   logic [2:0]  status;
   logic [2:0]  resp_status;
   logic        current;
   logic        last_id;

   always_comb begin
      current = (sess_ff.gen == ev.gen) && (sess_ff.handle == ev.handle);
      last_id = &next_id_ff;
      if (sess_ff.gen != ev.gen) begin
         resp_status = ST_STALE;
      end else if (sess_ff.handle != ev.handle) begin
         resp_status = ST_STALE_CONN;
      end else if (sess_ff.live != LIVE_WAITING || !sess_ff.active || sess_ff.consumed ||
                   sess_ff.pair_id == 32'd0) begin
         resp_status = ST_NOT_PENDING;
      end else if (sess_ff.pair_id != ev.pair_id) begin
         resp_status = ST_STALE_ID;
      end else begin
         resp_status = ST_OK;
      end
   end

   always_comb begin
      session_type upd;
      upd = sess_ff;
      upd.gen = ev.gen;
      upd.handle = ev.handle;
      upd.pair_id = 32'd0;
      upd.active = 1'b0;
      upd.consumed = 1'b0;
      sess_in = sess_ff;
      next_id_in = next_id_ff;
      status = ST_OK;
      unique case (ev.op)
         OP_CONNECT: begin
            sess_in = upd;
            sess_in.live = LIVE_SECURING;
         end
         OP_PASSKEY: begin
            if (!current || sess_ff.live == LIVE_IDLE) begin
               status = ST_STALE;
            end else if (sess_ff.live == LIVE_WAITING && sess_ff.pair_id != 32'd0) begin
               status = ST_DUP;
            end else if (sess_ff.exhausted || next_id_ff == 32'd0) begin
               sess_in = upd;
               sess_in.live = LIVE_IDLE;
               sess_in.last = LAST_POLICY;
               sess_in.exhausted = 1'b1;
               status = ST_EXHAUSTED;
            end else begin
               sess_in = upd;
               sess_in.live = LIVE_WAITING;
               sess_in.last = LAST_NONE;
               sess_in.pair_id = next_id_ff;
               sess_in.active = 1'b1;
               sess_in.exhausted = last_id;
               next_id_in = next_id_ff + 32'd1;
            end
         end
         OP_UNSUPPORTED: begin
            if (!current) begin
               status = ST_STALE;
            end else begin
               sess_in = upd;
               sess_in.live = LIVE_IDLE;
               sess_in.last = LAST_POLICY;
               status = ST_UNSUPPORTED;
            end
         end
         OP_RESPONSE: begin
            status = resp_status;
            if (resp_status == ST_OK) begin
               sess_in = upd;
               sess_in.live = LIVE_SECURING;
               sess_in.active = 1'b1;
               sess_in.consumed = 1'b1;
            end
         end
         OP_TIMEOUT: begin
            status = resp_status;
            if (resp_status == ST_OK) begin
               sess_in = upd;
               sess_in.live = LIVE_IDLE;
               sess_in.last = LAST_TIMEOUT;
            end
         end
         OP_COMPLETE: begin
            if (!current) begin
               status = ST_STALE;
            end else begin
               sess_in = upd;
               sess_in.live = LIVE_IDLE;
               sess_in.last = ev.result;
            end
         end
         OP_FAIL_CLOSED: begin
            sess_in = upd;
            sess_in.live = LIVE_IDLE;
            sess_in.last = ev.result;
         end
         OP_DISCONNECT: begin
            if (!current) begin
               status = ST_STALE;
            end else begin
               sess_in = upd;
               sess_in.live = LIVE_IDLE;
               sess_in.last = sess_ff.active ? LAST_PEER_DISC : sess_ff.last;
               sess_in.handle = NO_CONNECTION_HANDLE;
            end
         end
         OP_DISABLE, OP_RESET: begin
            sess_in = upd;
            sess_in.live = LIVE_IDLE;
            sess_in.last = LAST_NONE;
            sess_in.gen = sess_ff.gen;
            sess_in.handle = NO_CONNECTION_HANDLE;
         end
         OP_VALIDATE: begin
            status = resp_status;
         end
         default: begin
            status = ST_UNSUPPORTED;
         end
      endcase
   end

   assign res.status = status;
   assign res.sess = sess_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff.live <= LIVE_IDLE;
         sess_ff.last <= LAST_NONE;
         sess_ff.gen <= 32'd0;
         sess_ff.handle <= NO_CONNECTION_HANDLE;
         sess_ff.pair_id <= 32'd0;
         sess_ff.active <= 1'b0;
         sess_ff.consumed <= 1'b0;
         sess_ff.exhausted <= 1'b0;
         next_id_ff <= 32'd1;
      end else if (fire) begin
         sess_ff <= sess_in;
         next_id_ff <= next_id_in;
      end
   end

   `PPS_ASSERT_NEXT(a_exhausted_sticky, clock, reset, sess_ff.exhausted, sess_ff.exhausted)
   `PPS_ASSERT_NOW(a_zero_id_exhausted, clock, reset, next_id_ff == 32'd0, sess_ff.exhausted)
   `PPS_ASSERT_NOW(a_id_needs_active, clock, reset, sess_ff.pair_id != 32'd0, sess_ff.active)

endmodule

@@ sv/passkey_pairing_session_fsm.sv @@
// Top level of the passkey pairing session block: beat registers around the session core.
// The block tracks one pairing session and answers every event beat with one result beat.
// Request channel: req_valid with the event fields req_op, req_gen_in, req_handle_in,
// req_pair_id_in and req_result_in; a beat is taken when req_valid is high and req_stall
// is low. Response channel: rsp_valid with rsp_status and the stored session state after
// the event; a beat is delivered when rsp_valid is high and rsp_stall is low.
// Each event passes one input register, the session logic and one output register: a
// request beat is taken into the input register, and its result beat is presented once it
// moves into the output register. One event is taken every cycle while req_stall is low;
// the state registers are updated when an event moves into the output register, so the
// next event already sees the new state.
// When the receiver stalls, the output register holds its beat, one more event waits in
// the input register, and req_stall rises only when both are full.
// Reset clears the valid flags of both beat registers and puts the session in idle with
// no connection, generation zero, all flags clear and the next pairing id at one.
`include "passkey_pairing_session_fsm_assert.svh"

module passkey_pairing_session_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_op,
   input  logic [31:0] req_gen_in,
   input  logic [15:0] req_handle_in,
   input  logic [31:0] req_pair_id_in,
   input  logic [3:0]  req_result_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_live_out,
   output logic [3:0]  rsp_last_out,
   output logic [31:0] rsp_gen_out,
   output logic [15:0] rsp_handle_out,
   output logic [31:0] rsp_pair_id_out,
   output logic        rsp_active_out,
   output logic        rsp_consumed_out,
   output logic        rsp_exhausted_out
);
   import pps_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   event_type  ev_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type res;
   logic       advance;
   logic       take;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   pps_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .ev    (ev_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ev_ff.op <= req_op;
         ev_ff.gen <= req_gen_in;
         ev_ff.handle <= req_handle_in;
         ev_ff.pair_id <= req_pair_id_in;
         ev_ff.result <= req_result_in;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_live_out = out_ff.sess.live;
   assign rsp_last_out = out_ff.sess.last;
   assign rsp_gen_out = out_ff.sess.gen;
   assign rsp_handle_out = out_ff.sess.handle;
   assign rsp_pair_id_out = out_ff.sess.pair_id;
   assign rsp_active_out = out_ff.sess.active;
   assign rsp_consumed_out = out_ff.sess.consumed;
   assign rsp_exhausted_out = out_ff.sess.exhausted;

   `PPS_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   `PPS_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   `PPS_ASSERT_NEXT(a_waiting_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
